[rtl/lct_pkg.sv]
`timescale 1ns / 1ps

package lct_pkg;

  localparam int DEFAULT_ENTRIES = 64;

  localparam int IDX_FIELD_W = 6;
  localparam int LEN_FIELD_W = 7;

  localparam logic [1:0] MODE_LINK   = 2'd0;
  localparam logic [1:0] MODE_UNLINK = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [IDX_FIELD_W-1:0] first_entry;
    logic [IDX_FIELD_W-1:0] second_entry;
  } in_word_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] member;
    logic [LEN_FIELD_W-1:0] chain_length;
    logic                   is_last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BACK,
    ST_COUNT,
    ST_EMIT
  } lct_state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_link;
    logic wr_unlink;
    logic start;
    logic step;
    logic to_fwd;
    logic restart;
    logic emit;
    logic use_succ;
  } lct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first_ok;
    logic second_ok;
    logic link_ok;
    logic cap_hit;
    logic emit_last;
    logic out_free;
  } lct_sts_t;

endpackage

[rtl/lct_chan_if.sv]
`timescale 1ns / 1ps

interface lct_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/lct_datapath.sv]
`timescale 1ns / 1ps

module lct_datapath
  import lct_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  lct_cmd_t  cmd,
  output lct_sts_t  sts,
  input  logic      out_ready,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0]       CNT_CAP = CNT_W'(ENTRIES);
  localparam logic [LEN_FIELD_W-1:0] ENT_LIM = LEN_FIELD_W'(ENTRIES);

  // link tables: valid flags in flops (cleared on reset), indexes in memory
  logic             pred_v_r [ENTRIES];
  logic             succ_v_r [ENTRIES];
  logic [IDX_W-1:0] pred_mem [ENTRIES];
  logic [IDX_W-1:0] succ_mem [ENTRIES];

  logic             pred_rv_r;
  logic             succ_rv_r;
  logic [IDX_W-1:0] pred_ri_r;
  logic [IDX_W-1:0] succ_ri_r;

  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] head_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] total_r;

  logic             out_valid_r;
  out_word_t        out_word_r;

  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] b_idx;
  logic [IDX_W-1:0] link_idx;
  logic             link_ok;
  logic             emit_last;
  logic             out_free;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  assign a_idx     = in_word.first_entry[IDX_W-1:0];
  assign b_idx     = in_word.second_entry[IDX_W-1:0];
  assign link_idx  = cmd.use_succ ? succ_ri_r : pred_ri_r;
  assign link_ok   = cmd.use_succ ? succ_rv_r : pred_rv_r;
  assign emit_last = (cnt_r == total_r);
  assign out_free  = !out_valid_r || out_ready;

  assign sts.first_ok  = ({1'b0, in_word.first_entry} < ENT_LIM);
  assign sts.second_ok = ({1'b0, in_word.second_entry} < ENT_LIM);
  assign sts.link_ok   = link_ok;
  assign sts.cap_hit   = (cnt_r == CNT_CAP);
  assign sts.emit_last = emit_last;
  assign sts.out_free  = out_free;

  always_comb begin
    if (cmd.start) begin
      rd_addr = a_idx;
    end else if (cmd.to_fwd) begin
      rd_addr = cur_r;
    end else if (cmd.restart) begin
      rd_addr = head_r;
    end else begin
      rd_addr = link_idx;
    end
  end

  assign rd_en = cmd.start || cmd.step || cmd.to_fwd || cmd.restart ||
                 (cmd.emit && !emit_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        pred_v_r[i] <= 1'b0;
        succ_v_r[i] <= 1'b0;
      end
    end else if (cmd.wr_link || cmd.wr_unlink) begin
      pred_v_r[b_idx] <= cmd.wr_link;
      succ_v_r[a_idx] <= cmd.wr_link;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_link) begin
      pred_mem[b_idx] <= a_idx;
      succ_mem[a_idx] <= b_idx;
    end
  end

  // registered reads; data holds while no read is issued (output stall)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pred_ri_r <= pred_mem[rd_addr];
      succ_ri_r <= succ_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_rv_r <= 1'b0;
      succ_rv_r <= 1'b0;
    end else if (rd_en) begin
      pred_rv_r <= pred_v_r[rd_addr];
      succ_rv_r <= succ_v_r[rd_addr];
    end
  end

  // walk position and step counter, shared by all three passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.to_fwd) begin
      cnt_r <= CNT_W'(1);
    end else if (cmd.restart) begin
      total_r <= cnt_r;
      cnt_r   <= CNT_W'(1);
    end else if (cmd.emit && !emit_last) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_r <= a_idx;
    end else if (cmd.step) begin
      cur_r <= link_idx;
    end else if (cmd.restart) begin
      cur_r <= head_r;
    end else if (cmd.emit && !emit_last) begin
      cur_r <= link_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.to_fwd) begin
      head_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r.member       <= IDX_FIELD_W'(cur_r);
      out_word_r.chain_length <= LEN_FIELD_W'(total_r);
      out_word_r.is_last      <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_CAP)
    else $error("walk counter beyond table size");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (total_r != '0) && (total_r <= CNT_CAP))
    else $error("chain length out of range while emitting");

  // second forward pass must retrace the counting pass
  a_rewalk: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !emit_last) |-> succ_rv_r)
    else $error("emit pass lost a successor link");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && (out_word_r.is_last == $past(emit_last)))
    else $error("emitted word not loaded");

endmodule

[rtl/lct_ctrl.sv]
`timescale 1ns / 1ps

module lct_ctrl
  import lct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  input  lct_sts_t   sts,
  output logic       in_ready,
  output lct_cmd_t   cmd
);

  lct_state_t state_r;
  lct_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_mode == MODE_QUERY) && sts.first_ok) begin
          state_nxt = ST_BACK;
        end
      end
      ST_BACK: begin
        if (!(sts.link_ok && !sts.cap_hit)) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (!(sts.link_ok && !sts.cap_hit)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_mode)
            MODE_LINK:   cmd.wr_link   = sts.first_ok && sts.second_ok;
            MODE_UNLINK: cmd.wr_unlink = sts.first_ok && sts.second_ok;
            MODE_QUERY:  cmd.start     = sts.first_ok;
            default:     ;
          endcase
        end
      end
      ST_BACK: begin
        if (sts.link_ok && !sts.cap_hit) begin
          cmd.step = 1'b1;
        end else begin
          cmd.to_fwd = 1'b1;
        end
      end
      ST_COUNT: begin
        cmd.use_succ = 1'b1;
        if (sts.link_ok && !sts.cap_hit) begin
          cmd.step = 1'b1;
        end else begin
          cmd.restart = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.use_succ = 1'b1;
        cmd.emit     = sts.out_free;
      end
      default: ;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_link, cmd.wr_unlink, cmd.start, cmd.step,
              cmd.to_fwd, cmd.restart, cmd.emit}))
    else $error("conflicting datapath commands");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && sts.out_free && sts.emit_last) |=> state_r == ST_IDLE)
    else $error("query did not end after last member");

  a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == ST_BACK)
    else $error("query start did not enter backward walk");

endmodule

[rtl/linked_chain_table_top.sv]
`timescale 1ns / 1ps

// Table of ENTRIES entries, each with an optional predecessor and successor
// link. A link word (mode 0) makes first_entry the predecessor of
// second_entry, an unlink word (mode 1) clears those two links; both take
// one cycle and return nothing, as do mode 3 and words naming entries
// outside the table. A query word (mode 2) walks back from first_entry to
// the chain head, then forward to the tail, and returns one word per member,
// head first, each with the chain length and a last flag. Each link table
// has one registered read port, so a walk advances one link per cycle (the
// emit walk only while the result side is not stalled); the forward walk
// runs twice (once to count, once to emit). A query holds the input from
// its accept through the backward, count and emit passes, also while the
// result side stalls. The next word is taken in the cycle after the last
// member enters the output register.
// Walks are capped at ENTRIES steps, so looped chains always finish.
module linked_chain_table_top
  import lct_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  lct_chan_if.sink   in_ch,
  lct_chan_if.source out_ch
);

  lct_cmd_t  cmd;
  lct_sts_t  sts;
  in_word_t  in_word;
  out_word_t out_word;

  assign in_word     = in_ch.data;
  assign out_ch.data = out_word;

  lct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_word.mode),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  lct_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_word  (out_word)
  );

endmodule
